// File: rtl/ssc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ssc_pkg: shared types and constants
// Register indexes, widths and the decision record for the change reporter.
// ---------------------------------------------------------------------------
package ssc_pkg;

    localparam int FRACTION_BITS_DEF  = 10;
    localparam int READ_PERIOD_MS_DEF = 5000;
    localparam int VW = 32;

    localparam logic [2:0] REG_SEND_CYCLE = 3'd0;
    localparam logic [2:0] REG_OFFSET     = 3'd1;
    localparam logic [2:0] REG_DIVISOR    = 3'd2;
    localparam logic [2:0] REG_DELTA_PCT  = 3'd3;
    localparam logic [2:0] REG_DELTA_ABS  = 3'd4;
    localparam logic [2:0] REG_RAW_MODE   = 3'd5;

    typedef struct packed {
        logic read_done;
        logic valid;
        logic skip_smooth;
        logic send_base;
    } ssc_decide_t;

endpackage
`default_nettype wire

// File: rtl/ssc_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ssc_div: bit-serial signed divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ---------------------------------------------------------------------------
module ssc_div
    import ssc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [VW:0]   dividend,
    input  wire logic [7:0]           divisor,
    output logic                      done,
    output logic signed [VW:0]        quotient
);
    logic [VW:0]   rem_q_reg, rem_q_next;
    logic [8:0]    part_reg, part_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          neg_reg, neg_next;
    logic [7:0]    dvs_reg, dvs_next;
    logic [9:0]    trial;

    always_comb
    begin
        rem_q_next = rem_q_reg;
        part_next  = part_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        neg_next   = neg_reg;
        dvs_next   = dvs_reg;
        done       = 1'b0;
        trial      = {part_reg, rem_q_reg[VW]} - {2'b00, dvs_reg};
        if (start)
        begin
            rem_q_next = dividend[VW] ? (VW+1)'(0) - dividend : dividend;
            part_next  = '0;
            cnt_next   = 6'(VW + 1);
            busy_next  = 1'b1;
            neg_next   = dividend[VW];
            dvs_next   = (divisor == 8'd0) ? 8'd1 : divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[9])
            begin
                part_next  = trial[8:0];
                rem_q_next = {rem_q_reg[VW-1:0], 1'b1};
            end
            else
            begin
                part_next  = {part_reg[7:0], rem_q_reg[VW]};
                rem_q_next = {rem_q_reg[VW-1:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign quotient = neg_reg ? $signed((VW+1)'(0) - rem_q_next) : $signed(rem_q_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_q_reg <= rem_q_next;
        part_reg  <= part_next;
        neg_reg   <= neg_next;
        dvs_reg   <= dvs_next;
    end
endmodule
`default_nettype wire

// File: rtl/sensor_smooth_change_report.sv
`default_nettype none
// An accepted word that takes a valid sample passes through scale, divider
// start, 33 divider steps, the compare states ST_CMP and ST_CMP2 and output.
// A word that takes no sample, or an invalid one, goes straight to output.
// The input is ready only in the idle state; the output state holds the input
// off while the previous result word still waits to be taken.
// Reset: asynchronous active low; configuration registers clear to zero, the
// divisor to one, and kept, sent, send and read stamps clear to zero.
// ---------------------------------------------------------------------------
// sensor_smooth_change_report: smoothing and send-on-delta reporter
// Scales and corrects samples, smooths them and flags timed or delta bus sends.
// ---------------------------------------------------------------------------
module sensor_smooth_change_report
    import ssc_pkg::*;
#(
    parameter int FRACTION_BITS  = FRACTION_BITS_DEF,
    parameter int READ_PERIOD_MS = READ_PERIOD_MS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // now_ms[31:0], sample[63:32]
    input  wire logic [63:0] s_axis_tdata,
    // sample_valid[0], force_send[1]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // value_out[31:0]
    output logic [31:0]      m_axis_tdata,
    // read_done[0], value_stored[1], send_now[2]
    output logic [2:0]       m_axis_tuser
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCALE = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_CMP   = 6'b001000,
        ST_CMP2  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] cyc_reg;
    logic [7:0]  off_reg, div_reg, pct_reg;
    logic [15:0] abs_reg;
    logic        raw_reg;

    logic signed [VW-1:0] kept_reg, sent_reg;
    logic [31:0] send_t_reg, read_t_reg, now_reg;
    logic signed [VW-1:0] smp_reg, v_reg;
    logic signed [VW:0]   diff_reg;
    logic [VW:0]          mag_reg;
    logic        send_reg;
    ssc_decide_t dec_reg;
    logic [2:0]  ou_reg;
    logic [31:0] od_reg;
    logic        ov_reg;
    logic        div_go_reg;

    logic        div_start, div_done;
    logic signed [VW:0] div_q;

    ssc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff_reg),
        .divisor  (div_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Input-side decision, taken from the word on the port.
    logic [31:0] in_now, st_eff, cyc_ms;
    logic        in_force, due_send, due_read;
    always_comb
    begin
        in_now   = s_axis_tdata[31:0];
        st_eff   = s_axis_tuser[1] ? 32'd0 : send_t_reg;
        in_force = (st_eff == 32'd0);
        cyc_ms   = 32'(cyc_reg) * 32'd1000;
        due_send = in_force || (cyc_ms != 32'd0 && (in_now - st_eff) >= cyc_ms);
        due_read = (in_now - read_t_reg) >= 32'(READ_PERIOD_MS);
    end

    localparam int OFF_W = 8 + FRACTION_BITS;
    logic [OFF_W+3:0] off_num;
    logic [OFF_W+3:0] off_fix;
    logic [63:0]      off_prod;
    logic signed [47:0] scaled, withoff;
    logic signed [VW-1:0] sat1, sat2;
    always_comb
    begin
        off_num  = (OFF_W+4)'({off_reg, {FRACTION_BITS{1'b0}}}) + (OFF_W+4)'(5);
        // Divide by ten through a reciprocal that is exact for any 32-bit value.
        off_prod = 64'(off_num) * 64'h00000000CCCCCCCD;
        off_fix  = (OFF_W+4)'(off_prod >> 35);
        scaled  = raw_reg ? 48'(smp_reg) * 48'sd1000 : 48'(smp_reg);
        if (scaled > 48'sh7FFFFFFF)       sat1 = 32'sh7FFFFFFF;
        else if (scaled < -48'sh80000000) sat1 = 32'sh80000000;
        else                               sat1 = scaled[31:0];
        withoff = 48'(sat1) + 48'(off_fix);
        if (withoff > 48'sh7FFFFFFF) sat2 = 32'sh7FFFFFFF;
        else                          sat2 = withoff[31:0];
    end

    logic [47:0] lhs_pct, rhs_pct, lhs_abs, rhs_abs;
    always_comb
    begin
        lhs_pct = 48'(mag_reg) * 48'd100;
        rhs_pct = 48'(pct_reg) * 48'(sent_reg);
        lhs_abs = 48'(mag_reg) * 48'd10;
        rhs_abs = 48'({abs_reg, {FRACTION_BITS{1'b0}}});
    end

    logic acc_in, acc_out;
    assign acc_in  = s_axis_tvalid && s_axis_tready;
    assign acc_out = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;
    // The divider starts once the difference has settled in diff_reg.
    assign div_start = div_go_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (acc_in)
                      begin
                          if ((due_send || due_read) && s_axis_tuser[0]) state_next = ST_SCALE;
                          else state_next = ST_OUT;
                      end
            ST_SCALE: state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_CMP;
            ST_CMP:   state_next = ST_CMP2;
            ST_CMP2:  state_next = ST_OUT;
            ST_OUT:   if (!ov_reg || acc_out) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cyc_reg    <= '0;
            off_reg    <= '0;
            div_reg    <= 8'd1;
            pct_reg    <= '0;
            abs_reg    <= '0;
            raw_reg    <= 1'b0;
            kept_reg   <= '0;
            sent_reg   <= '0;
            send_t_reg <= '0;
            read_t_reg <= '0;
            ov_reg     <= 1'b0;
            dec_reg    <= '0;
            send_reg   <= 1'b0;
            div_go_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            div_go_reg <= (state_reg == ST_SCALE);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SEND_CYCLE: cyc_reg <= cfg_data;
                    REG_OFFSET:     off_reg <= cfg_data[7:0];
                    REG_DIVISOR:    div_reg <= cfg_data[7:0];
                    REG_DELTA_PCT:  pct_reg <= cfg_data[7:0];
                    REG_DELTA_ABS:  abs_reg <= cfg_data;
                    REG_RAW_MODE:   raw_reg <= cfg_data[0];
                    default:        ;
                endcase
            end
            if (acc_out && state_reg != ST_OUT) ov_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (acc_in)
                    begin
                        dec_reg.read_done   <= due_send || due_read;
                        dec_reg.valid       <= s_axis_tuser[0];
                        dec_reg.skip_smooth <= in_force && (kept_reg == '0);
                        dec_reg.send_base   <= due_send;
                        send_t_reg          <= st_eff;
                        if (due_send || due_read) read_t_reg <= in_now;
                    end
                ST_CMP:
                    send_reg <= dec_reg.send_base;
                ST_CMP2:
                begin
                    kept_reg <= v_reg;
                    if (sent_reg > 0 &&
                        ((pct_reg != 8'd0 && lhs_pct >= rhs_pct) ||
                         (abs_reg != 16'd0 && lhs_abs >= rhs_abs)))
                        send_reg <= 1'b1;
                end
                ST_OUT:
                    if (!ov_reg || acc_out)
                    begin
                        ov_reg <= 1'b1;
                        if (dec_reg.read_done && dec_reg.valid && send_reg)
                        begin
                            sent_reg   <= kept_reg;
                            send_t_reg <= (now_reg == 32'd0) ? 32'd1 : now_reg;
                        end
                    end
                default: ;
            endcase
        end
    end

    logic stored;
    assign stored = dec_reg.read_done && dec_reg.valid;

    always_ff @(posedge clk)
    begin
        if (acc_in)
        begin
            now_reg <= s_axis_tdata[31:0];
            smp_reg <= s_axis_tdata[63:32];
        end
        if (state_reg == ST_SCALE)
        begin
            v_reg    <= sat2;
            diff_reg <= (VW+1)'(sat2) - (VW+1)'(kept_reg);
        end
        if (div_done && !dec_reg.skip_smooth)
            v_reg <= VW'((VW+1)'(kept_reg) + div_q);
        if (state_reg == ST_CMP)
        begin
            diff_reg <= (VW+1)'(sent_reg) - (VW+1)'(v_reg);
            mag_reg  <= ((VW+1)'(sent_reg) >= (VW+1)'(v_reg))
                        ? (VW+1)'(sent_reg) - (VW+1)'(v_reg)
                        : (VW+1)'(v_reg) - (VW+1)'(sent_reg);
        end
        if (state_reg == ST_OUT && (!ov_reg || acc_out))
        begin
            od_reg <= stored ? v_reg : 32'd0;
            ou_reg <= {dec_reg.read_done && (stored ? send_reg : 1'b0), stored,
                       dec_reg.read_done};
        end
    end

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !ov_reg || state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_send_needs_store: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1])
        else $error("send without stored value");
    a_store_needs_read: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("store without read");
`endif
endmodule
`default_nettype wire
